// File: rtl/sfsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the section-filter slot manager.
// No dependencies; the top level and the checker import this package.
package sfsm_pkg;

    // request operation codes
    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_FREE  = 3'd1;
    localparam logic [2:0] MODE_SET   = 3'd2;
    localparam logic [2:0] MODE_START = 3'd3;
    localparam logic [2:0] MODE_STOP  = 3'd4;

    // response status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_REFUSED    = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_STOP_FIRST = 3'd3;
    localparam logic [2:0] ST_SET_FIRST  = 3'd4;

    // slot flag bit positions
    localparam int FLAG_INIT    = 0;
    localparam int FLAG_SET     = 1;
    localparam int FLAG_STARTED = 2;
    localparam int FLAG_STOPPED = 3;

    localparam logic [15:0] PID_MAX           = 16'h1FFF;
    localparam logic [31:0] ILLEGAL_OWNER_RST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  acs_id;
        logic [31:0] owner_handle;
        logic [15:0] pid;
        logic [7:0]  slot;
        logic [7:0]  pattern_length;
        logic        one_shot;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] granted_slot;
        logic       engine_start;
        logic       engine_stop;
        logic       engine_load;
        logic       engine_restart;
    } rsp_t;

    // per-slot owner and PID, written on allocate
    typedef struct packed {
        logic [31:0] owner;
        logic [12:0] pid;
    } meta_t;

    // per-slot mode, length and state flags
    typedef struct packed {
        logic       one_shot;
        logic [4:0] length;
        logic [3:0] flags;
    } ctl_t;

endpackage

// File: rtl/sfsm_if.sv
`timescale 1ns / 1ps
// Channel interfaces: request, response and configuration write.
// No dependencies.
interface sfsm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  acs_id;
    logic [31:0] owner_handle;
    logic [15:0] pid;
    logic [7:0]  slot;
    logic [7:0]  pattern_length;
    logic        one_shot;

    modport source (output valid, mode, acs_id, owner_handle, pid, slot, pattern_length,
                     one_shot, input ready);
    modport sink (input valid, mode, acs_id, owner_handle, pid, slot, pattern_length,
                   one_shot, output ready);
endinterface

interface sfsm_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] granted_slot;
    logic       engine_start;
    logic       engine_stop;
    logic       engine_load;
    logic       engine_restart;

    modport source (output valid, status, granted_slot, engine_start, engine_stop,
                     engine_load, engine_restart, input ready);
    modport sink (input valid, status, granted_slot, engine_start, engine_stop,
                   engine_load, engine_restart, output ready);
endinterface

interface sfsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] illegal_owner;

    modport source (output valid, illegal_owner, input ready);
    modport sink (input valid, illegal_owner, output ready);
endinterface

// File: rtl/sfsm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/section_filter_slot_manager_top.sv
`timescale 1ns / 1ps
// Section-filter slot manager, top level. Uses sfsm_pkg, sfsm_if, sfsm_ram.
// Sequence, accept to response valid: allocate scans every slot (one RAM read per slot
//   in the free-slot / PID-count scan), drains, then decides; free/set/start/stop read the
//   slot, then execute; a request refused on its arguments alone goes straight to the response.
// Throughput: one request at a time, req.ready high only while idle; the response waits for a free response register.
// Reset (rst_n, async, active low): all slots unused, illegal_owner all ones; RAMs uncleared.
module section_filter_slot_manager_top
    import sfsm_pkg::*;
#(
    parameter int SLOTS         = 32,
    parameter int PER_PID_LIMIT = 8,
    parameter int ACS_COUNT     = 2,
    parameter int MAX_PATTERN   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    sfsm_req_if.sink   req,
    sfsm_rsp_if.source rsp,
    sfsm_cfg_if.sink   cfg
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_AEND,
        S_LOOK,
        S_EXEC,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_data_reg, rsp_data_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [31:0]         illegal_reg, illegal_next;
    logic [SLOTS-1:0]    used_reg, used_next;

    // allocate scan: address issue counter, delayed check index, result trackers
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // slot RAM ports
    logic                meta_we, ctl_we;
    logic [IDX_W-1:0]    waddr, raddr;
    meta_t               meta_wdata, meta_rdata;
    ctl_t                ctl_wdata, ctl_rdata;

    logic [IDX_W-1:0]    slot_idx;
    logic                slot_ok;
    logic                running;

    sfsm_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (waddr),
        .wdata (meta_wdata),
        .raddr (raddr),
        .rdata (meta_rdata)
    );

    sfsm_ram #(.WIDTH($bits(ctl_t)), .DEPTH(SLOTS)) u_ctl_ram (
        .clk   (clk),
        .we    (ctl_we),
        .waddr (waddr),
        .wdata (ctl_wdata),
        .raddr (raddr),
        .rdata (ctl_rdata)
    );

    // config writes are to be issued only while idle, which the block does not enforce; they are always taken
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_data_reg.status;
    assign rsp.granted_slot   = rsp_data_reg.granted_slot;
    assign rsp.engine_start   = rsp_data_reg.engine_start;
    assign rsp.engine_stop    = rsp_data_reg.engine_stop;
    assign rsp.engine_load    = rsp_data_reg.engine_load;
    assign rsp.engine_restart = rsp_data_reg.engine_restart;

    // target slot of free/set/start/stop; range was checked at accept
    assign slot_idx = req_reg.slot[IDX_W-1:0];
    // a used slot whose stored owner became illegal is treated as invalid
    assign slot_ok  = used_reg[slot_idx] && (meta_rdata.owner != illegal_reg);
    assign running  = ctl_rdata.flags[FLAG_STARTED] && !ctl_rdata.flags[FLAG_STOPPED];

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg;
        illegal_next   = illegal_reg;
        used_next      = used_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_vld_next   = 1'b0;
        free_idx_next  = free_idx_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        meta_we        = 1'b0;
        ctl_we         = 1'b0;
        waddr          = slot_idx;
        raddr          = scan_idx_reg;
        meta_wdata     = '{owner: req_reg.owner_handle, pid: req_reg.pid[12:0]};
        ctl_wdata      = ctl_rdata;

        if (cfg.valid)
        begin
            illegal_next = cfg.illegal_owner;
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // scan check stage: RAM data for chk_idx arrived this cycle
        if (chk_vld_reg)
        begin
            if (!used_reg[chk_idx_reg])
            begin
                if (!found_reg)
                begin
                    free_idx_next = chk_idx_reg;
                    found_next    = 1'b1;
                end
            end
            else if (meta_rdata.pid == req_reg.pid[12:0])
            begin
                count_next = count_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = '{mode: req.mode, acs_id: req.acs_id,
                                 owner_handle: req.owner_handle, pid: req.pid,
                                 slot: req.slot, pattern_length: req.pattern_length,
                                 one_shot: req.one_shot};
                    res_next = '0;
                    if (req.mode == MODE_ALLOC)
                    begin
                        if (({1'b0, req.acs_id} >= 9'(ACS_COUNT)) ||
                            (req.owner_handle == illegal_reg) || (req.pid > PID_MAX))
                        begin
                            res_next.status = ST_REFUSED;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            scan_idx_next = '0;
                            found_next    = 1'b0;
                            count_next    = '0;
                            free_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    else if ((req.mode > MODE_STOP) || ({1'b0, req.slot} >= 9'(SLOTS)))
                    begin
                        res_next.status = ST_INVALID;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end

            S_SCAN:
            begin
                raddr         = scan_idx_reg;
                chk_idx_next  = scan_idx_reg;
                chk_vld_next  = 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                // last slot is checked this cycle
                state_next = S_AEND;
            end

            S_AEND:
            begin
                if (!found_reg || (10'(count_reg) >= 10'(PER_PID_LIMIT)))
                begin
                    res_next.status = ST_REFUSED;
                end
                else
                begin
                    waddr                   = free_idx_reg;
                    meta_we                 = 1'b1;
                    ctl_we                  = 1'b1;
                    ctl_wdata               = '0;
                    ctl_wdata.flags[FLAG_INIT] = 1'b1;
                    used_next[free_idx_reg] = 1'b1;
                    res_next.status         = ST_OK;
                    res_next.granted_slot   = 5'(free_idx_reg);
                end
                state_next = S_RESP;
            end

            S_LOOK:
            begin
                raddr      = slot_idx;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                if (!slot_ok)
                begin
                    res_next.status = ST_INVALID;
                end
                else
                begin
                    unique case (req_reg.mode)
                        MODE_FREE:
                        begin
                            if (running)
                            begin
                                res_next.status = ST_STOP_FIRST;
                            end
                            else
                            begin
                                // flags are rewritten on the next allocate
                                used_next[slot_idx] = 1'b0;
                            end
                        end
                        MODE_SET:
                        begin
                            if (req_reg.pattern_length > 8'(MAX_PATTERN))
                            begin
                                res_next.status = ST_INVALID;
                            end
                            else
                            begin
                                res_next.engine_load    = 1'b1;
                                res_next.engine_restart = running;
                                ctl_we                  = 1'b1;
                                ctl_wdata.one_shot      = req_reg.one_shot;
                                ctl_wdata.length        = req_reg.pattern_length[4:0];
                                ctl_wdata.flags[FLAG_SET] = 1'b1;
                            end
                        end
                        MODE_START:
                        begin
                            if (!ctl_rdata.flags[FLAG_SET])
                            begin
                                res_next.status = ST_SET_FIRST;
                            end
                            else if (!ctl_rdata.flags[FLAG_STARTED])
                            begin
                                res_next.engine_start         = 1'b1;
                                ctl_we                        = 1'b1;
                                ctl_wdata.flags[FLAG_STARTED] = 1'b1;
                            end
                        end
                        MODE_STOP:
                        begin
                            if (!ctl_rdata.flags[FLAG_STOPPED])
                            begin
                                res_next.engine_stop          = 1'b1;
                                ctl_we                        = 1'b1;
                                ctl_wdata.flags[FLAG_STOPPED] = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_INVALID;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            res_reg       <= '0;
            rsp_data_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            illegal_reg   <= ILLEGAL_OWNER_RST;
            used_reg      <= '0;
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            free_idx_reg  <= '0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            res_reg       <= res_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_valid_reg <= rsp_valid_next;
            illegal_reg   <= illegal_next;
            used_reg      <= used_next;
            scan_idx_reg  <= scan_idx_next;
            chk_idx_reg   <= chk_idx_next;
            chk_vld_reg   <= chk_vld_next;
            free_idx_reg  <= free_idx_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
        end
    end

endmodule

// File: rtl/sfsm_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the slot manager, bound to the top level.
// Depends on sfsm_pkg and section_filter_slot_manager_top.
module sfsm_checker
    import sfsm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic [2:0] status,
    input logic [4:0] granted_slot,
    input logic       engine_start,
    input logic       engine_stop,
    input logic       engine_load,
    input logic       engine_restart
);

    // one request in flight: busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    // at most one engine pulse per response
    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0({engine_start, engine_stop, engine_load}))
        else $error("more than one engine pulse");

    a_restart_with_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && engine_restart |-> engine_load)
        else $error("restart without load");

    // a granted slot or an engine pulse only comes with status ok
    a_ok_side_effects: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((granted_slot != 5'd0) || engine_start || engine_stop || engine_load)
        |-> (status == ST_OK))
        else $error("side effect on a failed request");

endmodule

bind section_filter_slot_manager_top sfsm_checker u_sfsm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .status         (rsp.status),
    .granted_slot   (rsp.granted_slot),
    .engine_start   (rsp.engine_start),
    .engine_stop    (rsp.engine_stop),
    .engine_load    (rsp.engine_load),
    .engine_restart (rsp.engine_restart)
);
